// File: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define FRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define FRC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/frc_pkg.sv
package frc_pkg;

    localparam int FRAME_BYTES = 91;
    localparam int CHUNK_BYTES = 8;
    localparam int NUM_CHUNKS  = (FRAME_BYTES + CHUNK_BYTES - 1) / CHUNK_BYTES;
    localparam int CHUNK_W     = $clog2(NUM_CHUNKS);
    localparam int LAST_BYTES  = FRAME_BYTES - (NUM_CHUNKS - 1) * CHUNK_BYTES;
    localparam int CSUM_INDEX  = 89;
    localparam int XOR_FIRST   = 3;
    localparam int XOR_LAST    = 88;
    localparam int DATA_FIRST  = 9;
    localparam int DATA_BYTES  = 6;
    localparam int RX_IDX_W    = 7;

    localparam logic [CHUNK_W-1:0]  LAST_CHUNK  = CHUNK_W'(NUM_CHUNKS - 1);
    localparam logic [3:0]          FULL_COUNT  = 4'(CHUNK_BYTES);
    localparam logic [3:0]          TAIL_COUNT  = 4'(LAST_BYTES);
    localparam logic [RX_IDX_W-1:0] RX_IDX_MAX  = {RX_IDX_W{1'b1}};
    localparam logic [RX_IDX_W-1:0] RX_FULL     = RX_IDX_W'(FRAME_BYTES);
    localparam logic [RX_IDX_W-1:0] RX_CSUM_MIN = RX_IDX_W'(CSUM_INDEX + 1);
    localparam logic [RX_IDX_W-1:0] RX_HDR_MIN  = RX_IDX_W'(DATA_FIRST);
    localparam logic [2:0]          DRAIN_LIMIT = 3'd5;

    localparam logic [7:0] SEQ_STEP      = 8'h08;
    localparam logic [7:0] CHAN_BASE     = 8'h05;
    localparam logic [7:0] MANUAL_ARG    = 8'h04;
    localparam logic [7:0] CMD_GROUP     = 8'h0d;
    localparam logic [7:0] CMD_MANUAL    = 8'h02;
    localparam logic [7:0] CMD_PERCENT   = 8'h0d;
    localparam logic [7:0] CMD_SPEED     = 8'h81;
    localparam logic [7:0] CMD_FIRMWARE  = 8'h87;
    localparam logic [7:0] LEN_SHORT     = 8'h03;
    localparam logic [7:0] LEN_SPEED     = 8'h06;
    localparam logic [7:0] DATA_LEAD     = 8'h01;
    localparam logic [7:0] DEV_BUSY      = 8'h01;
    localparam logic [7:0] DEV_READY     = 8'h02;
    localparam logic [7:0] DUTY_MAX      = 8'd100;

    typedef enum logic [0:0] {
        OP_SEND = 1'b0,
        OP_RECV = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        KIND_MANUAL   = 2'd0,
        KIND_PERCENT  = 2'd1,
        KIND_SPEED    = 2'd2,
        KIND_FIRMWARE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BUSY    = 3'd1,
        ST_SHORT   = 3'd2,
        ST_STALE   = 3'd3,
        ST_SEQ_ERR = 3'd4,
        ST_DEV_ERR = 3'd5
    } t_status;

    typedef struct packed {
        t_op        operation;
        t_kind      command_kind;
        logic [2:0] fan_channel;
        logic [7:0] duty_percent;
        logic [7:0] rx_byte;
        logic       rx_last;
    } t_req;

    typedef struct packed {
        logic [63:0] tx_chunk;
        logic [3:0]  tx_byte_count;
        logic        last_of_run;
        t_status     response_status;
        logic        checksum_ok;
        logic [15:0] speed_rpm;
        logic [7:0]  firmware_major;
        logic [7:0]  firmware_minor;
        logic [7:0]  firmware_patch;
    } t_rsp;

    function automatic logic [7:0] seq_advance(input logic [7:0] seq);
        logic [7:0] nxt;
        nxt = seq + SEQ_STEP;
        if (nxt == 8'h00) begin
            nxt = SEQ_STEP;
        end
        return nxt;
    endfunction

endpackage

// File: rtl/core/frc_stream_if.sv
interface frc_req_if;
    logic       valid;
    logic       ready;
    logic [0:0] operation;
    logic [1:0] command_kind;
    logic [2:0] fan_channel;
    logic [7:0] duty_percent;
    logic [7:0] rx_byte;
    logic       rx_last;

    modport source (
        output valid, operation, command_kind, fan_channel, duty_percent, rx_byte, rx_last,
        input  ready
    );
    modport sink (
        input  valid, operation, command_kind, fan_channel, duty_percent, rx_byte, rx_last,
        output ready
    );
endinterface

interface frc_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] tx_chunk;
    logic [3:0]  tx_byte_count;
    logic        last_of_run;
    logic [2:0]  response_status;
    logic        checksum_ok;
    logic [15:0] speed_rpm;
    logic [7:0]  firmware_major;
    logic [7:0]  firmware_minor;
    logic [7:0]  firmware_patch;

    modport source (
        output valid, tx_chunk, tx_byte_count, last_of_run, response_status, checksum_ok,
               speed_rpm, firmware_major, firmware_minor, firmware_patch,
        input  ready
    );
    modport sink (
        input  valid, tx_chunk, tx_byte_count, last_of_run, response_status, checksum_ok,
               speed_rpm, firmware_major, firmware_minor, firmware_patch,
        output ready
    );
endinterface

// File: rtl/core/fan_report_framer_checker.sv
// A result passes the input register, then the output register that drives the port;
// the framing stage waits while the output register holds a result not yet taken.
// Throughput: a response byte without rx_last moves on as the next arrives; a send
// occupies the framing stage for twelve chunks, one a cycle while the output is free.
// Reset (synchronous, active low) clears sequence numbers, response state and valid flags.
`include "assert_macros.svh"

module fan_report_framer_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    frc_req_if.sink       i_req,
    frc_rsp_if.source     o_rsp
);

    frc_pkg::t_req r_in;
    logic          r_in_valid;
    frc_pkg::t_rsp r_out;
    frc_pkg::t_rsp n_out;
    logic          r_out_valid;

    logic [frc_pkg::CHUNK_W-1:0]  r_chunk_idx;
    logic [frc_pkg::CHUNK_W-1:0]  n_chunk_idx;
    logic [7:0]                   r_seq_by_kind [4];
    logic [7:0]                   r_exp_seq;
    logic [7:0]                   n_exp_seq;
    logic [frc_pkg::RX_IDX_W-1:0] r_rx_idx;
    logic [frc_pkg::RX_IDX_W-1:0] n_rx_idx;
    logic [7:0]                   r_rx_xor;
    logic [7:0]                   n_rx_xor;
    logic [7:0]                   r_rx_status;
    logic [7:0]                   n_rx_status;
    logic [7:0]                   r_rx_seq;
    logic [7:0]                   n_rx_seq;
    logic [7:0]                   r_rx_data [frc_pkg::DATA_BYTES];
    logic [7:0]                   n_rx_data [frc_pkg::DATA_BYTES];
    logic [7:0]                   r_rx_csum;
    logic [7:0]                   n_rx_csum;
    logic                         r_draining;
    logic                         n_draining;
    logic [2:0]                   r_drain_reads;
    logic [2:0]                   n_drain_reads;

    logic       is_send;
    logic       need_out;
    logic       out_free;
    logic       stage_fire;
    logic       in_done;
    logic       seq_write;
    logic [7:0] seq_now;
    logic [7:0] fb6, fb7, fb8, fb9, fb10, fb11, fcsum;
    logic [7:0] duty_sat;
    logic [7:0] rx_b;
    logic [frc_pkg::RX_IDX_W-1:0] rx_count;
    logic [2:0] drain_inc;
    frc_pkg::t_status status;

    assign is_send    = (r_in.operation == frc_pkg::OP_SEND);
    assign need_out   = is_send || r_in.rx_last;
    assign out_free   = !r_out_valid || o_rsp.ready;
    assign stage_fire = r_in_valid && (!need_out || out_free);
    assign in_done    = stage_fire && (!is_send || (r_chunk_idx == frc_pkg::LAST_CHUNK));
    assign seq_write  = stage_fire && is_send && (r_chunk_idx == '0);
    assign i_req.ready = i_rst_n && (!r_in_valid || in_done);

    // frame fields of the held command
    always_comb begin
        duty_sat = (r_in.duty_percent > frc_pkg::DUTY_MAX) ? frc_pkg::DUTY_MAX
                                                           : r_in.duty_percent;
        fb6  = frc_pkg::LEN_SHORT;
        fb7  = frc_pkg::CMD_GROUP;
        fb8  = frc_pkg::CMD_MANUAL;
        fb9  = frc_pkg::DATA_LEAD;
        fb10 = frc_pkg::CHAN_BASE + {5'd0, r_in.fan_channel};
        fb11 = 8'h00;
        case (r_in.command_kind)
            frc_pkg::KIND_MANUAL: begin
                fb11 = frc_pkg::MANUAL_ARG;
            end
            frc_pkg::KIND_PERCENT: begin
                fb8  = frc_pkg::CMD_PERCENT;
                fb11 = duty_sat;
            end
            frc_pkg::KIND_SPEED: begin
                fb6 = frc_pkg::LEN_SPEED;
                fb8 = frc_pkg::CMD_SPEED;
            end
            frc_pkg::KIND_FIRMWARE: begin
                fb6  = 8'h00;
                fb7  = 8'h00;
                fb8  = frc_pkg::CMD_FIRMWARE;
                fb9  = 8'h00;
                fb10 = 8'h00;
            end
            default: begin
                fb6 = frc_pkg::LEN_SHORT;
            end
        endcase
        fcsum   = fb6 ^ fb7 ^ fb8 ^ fb9 ^ fb10 ^ fb11;
        seq_now = (r_chunk_idx == '0) ? frc_pkg::seq_advance(r_seq_by_kind[r_in.command_kind])
                                      : r_exp_seq;
    end

    always_comb begin
        rx_b          = r_in.rx_byte;
        n_chunk_idx   = r_chunk_idx;
        n_exp_seq     = r_exp_seq;
        n_rx_idx      = r_rx_idx;
        n_rx_xor      = r_rx_xor;
        n_rx_status   = r_rx_status;
        n_rx_seq      = r_rx_seq;
        n_rx_data     = r_rx_data;
        n_rx_csum     = r_rx_csum;
        n_draining    = r_draining;
        n_drain_reads = r_drain_reads;
        n_out         = '0;
        rx_count      = '0;
        drain_inc     = r_drain_reads + 3'd1;
        status        = frc_pkg::ST_OK;

        if (is_send) begin
            n_chunk_idx = (r_chunk_idx == frc_pkg::LAST_CHUNK) ? '0
                                                                : r_chunk_idx + frc_pkg::CHUNK_W'(1);
            n_out.tx_byte_count = frc_pkg::FULL_COUNT;
            case (r_chunk_idx)
                frc_pkg::CHUNK_W'(0): begin
                    n_out.tx_chunk = {fb7, fb6, 8'h00, 8'h00, 8'h00, seq_now, 8'h00, 8'h00};
                end
                frc_pkg::CHUNK_W'(1): begin
                    n_out.tx_chunk = {32'h0, fb11, fb10, fb9, fb8};
                end
                frc_pkg::LAST_CHUNK: begin
                    n_out.tx_chunk      = {40'h0, 8'h00, fcsum, 8'h00};
                    n_out.tx_byte_count = frc_pkg::TAIL_COUNT;
                    n_out.last_of_run   = 1'b1;
                end
                default: begin
                    n_out.tx_chunk = '0;
                end
            endcase
            if (r_chunk_idx == '0) begin
                n_exp_seq     = seq_now;
                n_rx_idx      = '0;
                n_rx_xor      = '0;
                n_rx_status   = '0;
                n_rx_seq      = '0;
                n_rx_csum     = '0;
                n_draining    = 1'b0;
                n_drain_reads = '0;
                for (int j = 0; j < frc_pkg::DATA_BYTES; j++) begin
                    n_rx_data[j] = '0;
                end
            end
        end else begin
            if (r_rx_idx == frc_pkg::RX_IDX_W'(1)) begin
                n_rx_status = rx_b;
            end
            if (r_rx_idx == frc_pkg::RX_IDX_W'(2)) begin
                n_rx_seq = rx_b;
            end
            for (int j = 0; j < frc_pkg::DATA_BYTES; j++) begin
                if (r_rx_idx == frc_pkg::RX_IDX_W'(frc_pkg::DATA_FIRST + j)) begin
                    n_rx_data[j] = rx_b;
                end
            end
            if (r_rx_idx >= frc_pkg::RX_IDX_W'(frc_pkg::XOR_FIRST) &&
                r_rx_idx <= frc_pkg::RX_IDX_W'(frc_pkg::XOR_LAST)) begin
                n_rx_xor = r_rx_xor ^ rx_b;
            end
            if (r_rx_idx == frc_pkg::RX_IDX_W'(frc_pkg::CSUM_INDEX)) begin
                n_rx_csum = rx_b;
            end
            if (r_rx_idx != frc_pkg::RX_IDX_MAX) begin
                n_rx_idx = r_rx_idx + frc_pkg::RX_IDX_W'(1);
            end
            rx_count = n_rx_idx;

            if (r_in.rx_last) begin
                if (r_draining) begin
                    if (rx_count >= frc_pkg::RX_HDR_MIN && n_rx_status == frc_pkg::DEV_READY &&
                        n_rx_seq == r_exp_seq) begin
                        status        = frc_pkg::ST_OK;
                        n_draining    = 1'b0;
                        n_drain_reads = '0;
                    end else if (drain_inc >= frc_pkg::DRAIN_LIMIT) begin
                        status        = frc_pkg::ST_SEQ_ERR;
                        n_draining    = 1'b0;
                        n_drain_reads = '0;
                    end else begin
                        status        = frc_pkg::ST_STALE;
                        n_drain_reads = drain_inc;
                    end
                end else if (rx_count < frc_pkg::RX_FULL) begin
                    status = frc_pkg::ST_SHORT;
                end else if (n_rx_status == frc_pkg::DEV_BUSY) begin
                    status = frc_pkg::ST_BUSY;
                end else if (n_rx_seq != r_exp_seq) begin
                    status        = frc_pkg::ST_STALE;
                    n_draining    = 1'b1;
                    n_drain_reads = '0;
                end else if (n_rx_status != frc_pkg::DEV_READY) begin
                    status = frc_pkg::ST_DEV_ERR;
                end else begin
                    status = frc_pkg::ST_OK;
                end

                n_out.last_of_run     = 1'b1;
                n_out.response_status = status;
                n_out.checksum_ok     = (rx_count >= frc_pkg::RX_CSUM_MIN) &&
                                        (n_rx_csum == n_rx_xor);
                if (status == frc_pkg::ST_OK) begin
                    n_out.speed_rpm      = {n_rx_data[4], n_rx_data[5]};
                    n_out.firmware_major = n_rx_data[0];
                    n_out.firmware_minor = n_rx_data[1];
                    n_out.firmware_patch = n_rx_data[2];
                end

                n_rx_idx    = '0;
                n_rx_xor    = '0;
                n_rx_status = '0;
                n_rx_seq    = '0;
                n_rx_csum   = '0;
                for (int j = 0; j < frc_pkg::DATA_BYTES; j++) begin
                    n_rx_data[j] = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_chunk_idx   <= '0;
            r_exp_seq     <= '0;
            r_rx_idx      <= '0;
            r_rx_xor      <= '0;
            r_rx_status   <= '0;
            r_rx_seq      <= '0;
            r_rx_csum     <= '0;
            r_draining    <= 1'b0;
            r_drain_reads <= '0;
            for (int k = 0; k < 4; k++) begin
                r_seq_by_kind[k] <= '0;
            end
            for (int j = 0; j < frc_pkg::DATA_BYTES; j++) begin
                r_rx_data[j] <= '0;
            end
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_in_valid <= 1'b1;
                r_in       <= '{operation:    frc_pkg::t_op'(i_req.operation),
                                command_kind: frc_pkg::t_kind'(i_req.command_kind),
                                fan_channel:  i_req.fan_channel,
                                duty_percent: i_req.duty_percent,
                                rx_byte:      i_req.rx_byte,
                                rx_last:      i_req.rx_last};
            end else if (in_done) begin
                r_in_valid <= 1'b0;
            end

            if (stage_fire && need_out) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            if (stage_fire) begin
                r_chunk_idx   <= n_chunk_idx;
                r_exp_seq     <= n_exp_seq;
                r_rx_idx      <= n_rx_idx;
                r_rx_xor      <= n_rx_xor;
                r_rx_status   <= n_rx_status;
                r_rx_seq      <= n_rx_seq;
                r_rx_data     <= n_rx_data;
                r_rx_csum     <= n_rx_csum;
                r_draining    <= n_draining;
                r_drain_reads <= n_drain_reads;
            end
            if (seq_write) begin
                r_seq_by_kind[r_in.command_kind] <= seq_now;
            end
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.tx_chunk        = r_out.tx_chunk;
    assign o_rsp.tx_byte_count   = r_out.tx_byte_count;
    assign o_rsp.last_of_run     = r_out.last_of_run;
    assign o_rsp.response_status = r_out.response_status;
    assign o_rsp.checksum_ok     = r_out.checksum_ok;
    assign o_rsp.speed_rpm       = r_out.speed_rpm;
    assign o_rsp.firmware_major  = r_out.firmware_major;
    assign o_rsp.firmware_minor  = r_out.firmware_minor;
    assign o_rsp.firmware_patch  = r_out.firmware_patch;

    `FRC_ASSERT_IMP(a_chunk_only_on_send, r_chunk_idx != '0,
        r_in_valid && r_in.operation == frc_pkg::OP_SEND, "chunk counter runs without a send")
    `FRC_ASSERT_IMP(a_chunk_no_status, o_rsp.valid && o_rsp.tx_byte_count != 4'd0,
        o_rsp.response_status == frc_pkg::ST_OK && !o_rsp.checksum_ok, "chunk carries status")
    `FRC_ASSERT_IMP(a_seq_nonzero, $past(i_rst_n) && !$stable(r_exp_seq),
        r_exp_seq != 8'h00, "sequence number stepped to zero")
    `FRC_ASSERT_IMP(a_drain_bound, r_draining,
        r_drain_reads < frc_pkg::DRAIN_LIMIT, "drain count passed its limit")

endmodule

// File: dv/fan_report_framer_checker_tb.sv
`timescale 1ns / 100ps

module fan_report_framer_checker_tb;
    import frc_pkg::*;

    localparam int RANDOM_TRANSACTIONS = 5;
    localparam int IDLE_PERCENT        = 6;
    localparam int HOLD_CYCLES         = 300;
    localparam int SETTLE_CYCLES       = 20;
    localparam int CYCLE_LIMIT         = 400000;

    logic i_clk;
    logic i_rst_n;

    frc_req_if req_if ();
    frc_rsp_if rsp_if ();

    fan_report_framer_checker u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Predicted protocol state
    logic [7:0] kind_seq [4];
    logic [7:0] last_sent_seq;
    logic [6:0] rsp_count;
    logic [7:0] rsp_xor;
    logic [7:0] rsp_status;
    logic [7:0] rsp_seq;
    logic [7:0] rsp_csum;
    logic [7:0] rsp_data [DATA_BYTES];
    logic       in_drain;
    logic [2:0] drain_count;

    t_rsp chunk_report_q [$];

    int          mismatches   = 0;
    int          results_seen = 0;
    int          items_sent   = 0;
    int          frames_sent  = 0;
    int          status_hits [6] = '{default: 0};
    int unsigned cycle_count  = 0;
    logic        quiet;
    logic        rsp_hold;
    event        hold_go;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic clear_response();
        rsp_count  = '0;
        rsp_xor    = '0;
        rsp_status = '0;
        rsp_seq    = '0;
        rsp_csum   = '0;
        foreach (rsp_data[i]) rsp_data[i] = '0;
    endtask

    task automatic frame_or_classify(input t_req r);
        logic [7:0] frame [FRAME_BYTES];
        logic [7:0] seq;
        logic [7:0] x;
        logic [6:0] idx;
        t_rsp       o;
        if (r.operation == OP_SEND) begin
            seq = kind_seq[r.command_kind] + SEQ_STEP;
            if (seq == 8'h00) begin
                seq = SEQ_STEP;
            end
            kind_seq[r.command_kind] = seq;
            last_sent_seq = seq;
            foreach (frame[i]) frame[i] = 8'h00;
            frame[2] = seq;
            if (r.command_kind != KIND_FIRMWARE) begin
                frame[6]  = (r.command_kind == KIND_SPEED) ? LEN_SPEED : LEN_SHORT;
                frame[7]  = CMD_GROUP;
                frame[9]  = DATA_LEAD;
                frame[10] = CHAN_BASE + 8'(r.fan_channel);
            end
            case (r.command_kind)
                KIND_MANUAL: begin
                    frame[8]  = CMD_MANUAL;
                    frame[11] = MANUAL_ARG;
                end
                KIND_PERCENT: begin
                    frame[8]  = CMD_PERCENT;
                    frame[11] = (r.duty_percent > DUTY_MAX) ? DUTY_MAX : r.duty_percent;
                end
                KIND_SPEED: begin
                    frame[8] = CMD_SPEED;
                end
                default: begin
                    frame[8] = CMD_FIRMWARE;
                end
            endcase
            x = 8'h00;
            for (int i = XOR_FIRST; i <= XOR_LAST; i++) x ^= frame[i];
            frame[CSUM_INDEX] = x;
            clear_response();
            in_drain    = 1'b0;
            drain_count = '0;
            for (int k = 0; k < NUM_CHUNKS; k++) begin
                o = '0;
                for (int i = 0; i < CHUNK_BYTES; i++) begin
                    if (k * CHUNK_BYTES + i < FRAME_BYTES) begin
                        o.tx_chunk[8*i +: 8] = frame[k * CHUNK_BYTES + i];
                        o.tx_byte_count      = o.tx_byte_count + 4'd1;
                    end
                end
                o.last_of_run = (k == NUM_CHUNKS - 1);
                chunk_report_q.push_back(o);
            end
            frames_sent++;
        end else begin
            idx = rsp_count;
            if (idx == 1) begin
                rsp_status = r.rx_byte;
            end else if (idx == 2) begin
                rsp_seq = r.rx_byte;
            end
            if (idx >= DATA_FIRST && idx < DATA_FIRST + DATA_BYTES) begin
                rsp_data[idx - DATA_FIRST] = r.rx_byte;
            end
            if (idx >= XOR_FIRST && idx <= XOR_LAST) begin
                rsp_xor ^= r.rx_byte;
            end
            if (idx == CSUM_INDEX) begin
                rsp_csum = r.rx_byte;
            end
            if (rsp_count != RX_IDX_MAX) begin
                rsp_count = rsp_count + 7'd1;
            end
            if (r.rx_last) begin
                o = '0;
                o.last_of_run = 1'b1;
                o.checksum_ok = (rsp_count >= RX_CSUM_MIN) && (rsp_csum == rsp_xor);
                if (in_drain) begin
                    if (rsp_count >= RX_HDR_MIN && rsp_status == DEV_READY &&
                        rsp_seq == last_sent_seq) begin
                        o.response_status = ST_OK;
                        in_drain    = 1'b0;
                        drain_count = '0;
                    end else begin
                        drain_count = drain_count + 3'd1;
                        if (drain_count >= DRAIN_LIMIT) begin
                            o.response_status = ST_SEQ_ERR;
                            in_drain    = 1'b0;
                            drain_count = '0;
                        end else begin
                            o.response_status = ST_STALE;
                        end
                    end
                end else if (rsp_count < RX_FULL) begin
                    o.response_status = ST_SHORT;
                end else if (rsp_status == DEV_BUSY) begin
                    o.response_status = ST_BUSY;
                end else if (rsp_seq != last_sent_seq) begin
                    o.response_status = ST_STALE;
                    in_drain    = 1'b1;
                    drain_count = '0;
                end else if (rsp_status != DEV_READY) begin
                    o.response_status = ST_DEV_ERR;
                end else begin
                    o.response_status = ST_OK;
                end
                if (o.response_status == ST_OK) begin
                    o.speed_rpm      = {rsp_data[4], rsp_data[5]};
                    o.firmware_major = rsp_data[0];
                    o.firmware_minor = rsp_data[1];
                    o.firmware_patch = rsp_data[2];
                end
                chunk_report_q.push_back(o);
                status_hits[int'(o.response_status)]++;
                clear_response();
            end
        end
    endtask

    function automatic t_req rand_req(input t_op op);
        t_req r;
        r.operation    = op;
        r.command_kind = t_kind'($urandom_range(3));
        r.fan_channel  = 3'($urandom_range(7));
        r.duty_percent = 8'($urandom_range(255));
        r.rx_byte      = 8'($urandom_range(255));
        r.rx_last      = 1'($urandom_range(1));
        return r;
    endfunction

    function automatic logic [7:0] wrong_seq();
        return last_sent_seq + 8'($urandom_range(255, 1));
    endfunction

    task automatic send_item(input t_req r);
        int gaps;
        gaps = 0;
        if (!quiet) begin
            while ($urandom_range(99) < IDLE_PERCENT) gaps++;
        end
        if (gaps > 0) begin
            req_if.valid <= 1'b0;
            repeat (gaps) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.operation    <= r.operation;
        req_if.command_kind <= r.command_kind;
        req_if.fan_channel  <= r.fan_channel;
        req_if.duty_percent <= r.duty_percent;
        req_if.rx_byte      <= r.rx_byte;
        req_if.rx_last      <= r.rx_last;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        frame_or_classify(r);
        items_sent++;
    endtask

    task automatic send_command(input t_kind kind, input logic [2:0] chan,
                                input logic [7:0] duty);
        t_req r;
        r = rand_req(OP_SEND);
        r.command_kind = kind;
        r.fan_channel  = chan;
        r.duty_percent = duty;
        send_item(r);
    endtask

    task automatic send_response(input int len, input logic [7:0] status_byte,
                                 input logic [7:0] seq_byte, input bit good_csum,
                                 input bit mark_last);
        t_req       r;
        logic [7:0] x;
        x = 8'h00;
        for (int i = 0; i < len; i++) begin
            r = rand_req(OP_RECV);
            if (i == 1) begin
                r.rx_byte = status_byte;
            end else if (i == 2) begin
                r.rx_byte = seq_byte;
            end else if (i == CSUM_INDEX && good_csum) begin
                r.rx_byte = x;
            end
            if (i >= XOR_FIRST && i <= XOR_LAST) begin
                x ^= r.rx_byte;
            end
            r.rx_last = mark_last && (i == len - 1);
            send_item(r);
        end
    endtask

    task automatic test_full_frames();
        send_command(KIND_SPEED, 3'd3, 8'd0);
        // stale full response, then reads that drain it
        send_response(FRAME_BYTES, DEV_READY, wrong_seq(), 1'b1, 1'b1);
        repeat (DRAIN_LIMIT - 2) send_response(2, DEV_READY, last_sent_seq, 1'b1, 1'b1);
        send_response(15, DEV_READY, last_sent_seq, 1'b1, 1'b1);
    endtask

    task automatic test_send_extremes();
        send_command(KIND_MANUAL, 3'd0, 8'd0);
        send_command(KIND_PERCENT, 3'd7, 8'd0);
        send_command(KIND_PERCENT, 3'd1, DUTY_MAX);
        send_command(KIND_PERCENT, 3'd2, DUTY_MAX + 8'd1);
        send_command(KIND_PERCENT, 3'd7, 8'hff);
        send_command(KIND_SPEED, 3'd7, 8'hff);
        send_command(KIND_FIRMWARE, 3'd0, 8'h55);
        send_command(KIND_MANUAL, 3'd7, 8'haa);
    endtask

    task automatic test_short_responses();
        send_response(1, DEV_READY, last_sent_seq, 1'b1, 1'b1);
        // abandon a partial response with a new command
        send_response(6, DEV_READY, last_sent_seq, 1'b1, 1'b0);
        send_command(KIND_FIRMWARE, 3'd4, 8'd50);
        send_response(10, DEV_READY, last_sent_seq, 1'b1, 1'b1);
    endtask

    task automatic test_sequence_wrap();
        quiet <= 1'b1;
        repeat (33) send_command(KIND_MANUAL, 3'($urandom_range(7)), 8'($urandom_range(255)));
        quiet <= 1'b0;
    endtask

    task automatic test_backpressure();
        -> hold_go;
        repeat (4) begin
            send_command(t_kind'($urandom_range(3)), 3'($urandom_range(7)),
                         8'($urandom_range(255)));
        end
        send_response(3, DEV_READY, last_sent_seq, 1'b1, 1'b1);
    endtask

    task automatic test_random();
        int         pick;
        logic [7:0] status_byte;
        logic [7:0] seq_byte;
        for (int n = 0; n < RANDOM_TRANSACTIONS; n++) begin
            pick        = $urandom_range(99);
            status_byte = ($urandom_range(9) < 8) ? DEV_READY :
                          ($urandom_range(1) != 0) ? DEV_BUSY : 8'($urandom_range(255));
            seq_byte    = ($urandom_range(9) < 8) ? last_sent_seq : wrong_seq();
            if (pick < 30) begin
                send_command(t_kind'($urandom_range(3)), 3'($urandom_range(7)),
                             8'($urandom_range(255)));
            end else if (pick < 80) begin
                send_response($urandom_range(14, 1), status_byte, seq_byte, 1'b1, 1'b1);
            end else begin
                send_response($urandom_range(6, 1), status_byte, seq_byte, 1'b1, 1'b0);
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (chunk_report_q.size() == 0) begin
                $display("%0t: unexpected transfer, expected none actual chunk %0h status %0d",
                         $time, rsp_if.tx_chunk, rsp_if.response_status);
                mismatches++;
            end else begin
                want = chunk_report_q.pop_front();
                compare_field("tx_chunk", want.tx_chunk, rsp_if.tx_chunk);
                compare_field("tx_byte_count", want.tx_byte_count, rsp_if.tx_byte_count);
                compare_field("last_of_run", want.last_of_run, rsp_if.last_of_run);
                compare_field("response_status", want.response_status,
                              rsp_if.response_status);
                compare_field("checksum_ok", want.checksum_ok, rsp_if.checksum_ok);
                compare_field("speed_rpm", want.speed_rpm, rsp_if.speed_rpm);
                compare_field("firmware_major", want.firmware_major, rsp_if.firmware_major);
                compare_field("firmware_minor", want.firmware_minor, rsp_if.firmware_minor);
                compare_field("firmware_patch", want.firmware_patch, rsp_if.firmware_patch);
                results_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_if.ready <= !rsp_hold && (quiet || $urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // hold off the result side long enough for the block to fill up
    initial begin
        rsp_hold <= 1'b0;
        forever begin
            @(hold_go);
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rsp_hold <= 1'b0;
        end
    end

    initial begin
        req_if.valid        <= 1'b0;
        req_if.operation    <= '0;
        req_if.command_kind <= '0;
        req_if.fan_channel  <= '0;
        req_if.duty_percent <= '0;
        req_if.rx_byte      <= '0;
        req_if.rx_last      <= 1'b0;
        quiet               <= 1'b0;
        i_rst_n             <= 1'b0;
        foreach (kind_seq[i]) kind_seq[i] = '0;
        last_sent_seq = '0;
        in_drain      = 1'b0;
        drain_count   = '0;
        clear_response();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_full_frames();
        test_send_extremes();
        test_short_responses();
        test_sequence_wrap();
        test_backpressure();
        test_random();

        req_if.valid <= 1'b0;
        while (chunk_report_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run: %0d transfers in, %0d frames built, %0d results checked",
                 items_sent, frames_sent, results_seen);
        $display("Reports: ok %0d busy %0d short %0d stale %0d seq err %0d dev err %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4], status_hits[5]);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/frc_pkg.sv
rtl/core/frc_stream_if.sv
rtl/core/fan_report_framer_checker.sv
dv/fan_report_framer_checker_tb.sv
